>>> design/itoa_pkg.sv
// Shared types and constants for the integer to decimal text converter.
`default_nettype none
package itoa_pkg;

   localparam int VALUE_W     = 32;
   localparam int CHAR_W      = 8;
   localparam int DIGIT_W     = 4;
   localparam int MAX_DIGITS  = 10;
   localparam int DIGIT_CNT_W = 4;

   localparam logic [CHAR_W-1:0] DIGIT_BASE_CODE = 8'd48;
   localparam logic [CHAR_W-1:0] MINUS_CODE      = 8'd45;
   localparam logic [CHAR_W-1:0] NINE_CODE       = 8'd57;

   // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
   localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int                 RECIP_SHIFT = 35;
   localparam int                 QUOT_W      = 2 * VALUE_W - RECIP_SHIFT;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = 1;
   localparam int QUEUE_CW    = 2;

   typedef struct packed {
      logic               neg;
      logic [VALUE_W-1:0] mag;
   } work_type;

   typedef struct packed {
      logic     valid;
      work_type work;
   } queue_head_type;

endpackage
`default_nettype wire

>>> design/int_to_decimal_ascii_top.sv
// Top level of the signed 32-bit integer to decimal ASCII text converter.
//
// Input stream (req_*): one beat carries one signed 32-bit integer in req_tdata.
// Output stream (rsp_*): one beat per text character, most significant first,
// rsp_tdata holds the ASCII code, rsp_tlast marks the final character of a number.
// Negative values start with '-'; zero gives a single '0'; no leading zeros.
// The front queues up to two numbers as sign and magnitude, so req_tready stays
// high while the back end is busy until that queue is full.
// The back end peels one digit at a time on a shared 32x32 reciprocal
// multiplier (multiply, then quotient and remainder), then sends one character
// per cycle from its output register while rsp_tready is high.
// A stalled rsp_tready holds the current character and pauses digit emission;
// the queue keeps taking input until it fills.
// Reset (synchronous, active high) empties the queue and drops any pending text.
`default_nettype none
module int_to_decimal_ascii_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] character
   output logic             rsp_tlast
);
   import itoa_pkg::*;

   queue_head_type head;
   logic           head_pop;

   itoa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .head       (head),
      .head_pop   (head_pop)
   );

   itoa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_pop   (head_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

>>> design/itoa_front.sv
// Front end: takes input beats, splits sign and magnitude, queues them for the back end.
`default_nettype none
module itoa_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [itoa_pkg::VALUE_W-1:0] req_tdata,
   output itoa_pkg::queue_head_type        head,
   input  wire logic                       head_pop
);
   import itoa_pkg::*;

   work_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]    count_ff, count_in;
   work_type               classified;
   logic                   push, pop;

   always_comb begin
      classified.neg = req_tdata[VALUE_W-1];
      classified.mag = classified.neg ? (VALUE_W'(0) - req_tdata) : req_tdata;
   end

   assign req_tready = (count_ff != QUEUE_CW'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign pop        = head_pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.work  = entry_ff[rd_ptr_ff];

endmodule
`default_nettype wire

>>> design/itoa_back.sv
// Back end: peels decimal digits with a reciprocal multiply, then emits them as text beats.
`default_nettype none
module itoa_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  itoa_pkg::queue_head_type         head,
   output logic                             head_pop,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [itoa_pkg::CHAR_W-1:0]      rsp_tdata,
   output logic                             rsp_tlast
);
   import itoa_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [VALUE_W-1:0]     mag_ff, mag_in;
   logic [2*VALUE_W-1:0]   prod_ff, prod_in;
   logic                   sign_ff, sign_in;
   logic [DIGIT_W-1:0]     stack_ff [MAX_DIGITS];
   logic [DIGIT_W-1:0]     stack_in [MAX_DIGITS];
   logic [DIGIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]      rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [QUOT_W-1:0]      quot;
   logic [VALUE_W-1:0]     quot_ext;
   logic [VALUE_W-1:0]     quot_x10;
   logic [VALUE_W-1:0]     rem_w;
   logic                   out_free;

   always_comb begin
      quot     = prod_ff[2*VALUE_W-1:RECIP_SHIFT];
      quot_ext = VALUE_W'(quot);
      quot_x10 = {quot_ext[VALUE_W-4:0], 3'b000} + {quot_ext[VALUE_W-2:0], 1'b0};
      rem_w    = mag_ff - quot_x10;
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      prod_in      = prod_ff;
      sign_in      = sign_ff;
      cnt_in       = cnt_ff;
      stack_in     = stack_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      head_pop     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               head_pop = 1'b1;
               mag_in   = head.work.mag;
               sign_in  = head.work.neg;
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = {{VALUE_W{1'b0}}, mag_ff} * {{VALUE_W{1'b0}}, RECIP_TEN};
            state_in = ST_DIV;
         end
         ST_DIV: begin
            for (int i = 1; i < MAX_DIGITS; i++) begin
               stack_in[i] = stack_ff[i-1];
            end
            stack_in[0] = rem_w[DIGIT_W-1:0];
            cnt_in      = cnt_ff + 1'b1;
            mag_in      = quot_ext;
            state_in    = (quot == '0) ? ST_EMIT : ST_MUL;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (sign_ff) begin
                  sign_in     = 1'b0;
                  rsp_char_in = MINUS_CODE;
                  rsp_last_in = 1'b0;
               end else begin
                  rsp_char_in = DIGIT_BASE_CODE + CHAR_W'(stack_ff[0]);
                  rsp_last_in = (cnt_ff == DIGIT_CNT_W'(1));
                  for (int i = 0; i < MAX_DIGITS - 1; i++) begin
                     stack_in[i] = stack_ff[i+1];
                  end
                  stack_in[MAX_DIGITS-1] = '0;
                  cnt_in = cnt_ff - 1'b1;
                  if (cnt_ff == DIGIT_CNT_W'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sign_ff      <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sign_ff      <= sign_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      prod_ff     <= prod_in;
      stack_ff    <= stack_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

>>> design/itoa_checker.sv
// Port-level checks for the converter, bound to the top level.
`default_nettype none
module itoa_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        rsp_tlast
);
   import itoa_pkg::*;

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled rsp beat changed");

   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata == MINUS_CODE) ||
                     ((rsp_tdata >= DIGIT_BASE_CODE) && (rsp_tdata <= NINE_CODE)))
      else $error("rsp character is not a sign or digit");

   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata == MINUS_CODE) |-> !rsp_tlast)
      else $error("sign character marked last");

endmodule

bind int_to_decimal_ascii_top itoa_checker u_itoa_checker (.*);
`default_nettype wire

>>> tb/sv/tb.sv
// Stream testbench for the signed integer to decimal ASCII text converter.
`default_nettype none
module tb;
   import itoa_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 60;
   localparam int HOLD_OFF_CYCLES = 300;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } text_char_type;

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [VALUE_W-1:0] req_tdata;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [CHAR_W-1:0]  rsp_tdata;
   logic               rsp_tlast;

   text_char_type expected_text[$];
   int            fail_count;
   int            send_idle_pct;
   int            rsp_idle_pct;
   int            hold_cycles;
   int            quiet_cycles;

   int_to_decimal_ascii_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // expected characters of one number, sign first, no leading zeros
   function automatic void predict_text(input logic [VALUE_W-1:0] value);
      logic               neg;
      logic [VALUE_W-1:0] mag;
      logic [DIGIT_W-1:0] digits[MAX_DIGITS];
      int                 nd;
      text_char_type      tc;
      neg = value[VALUE_W-1];
      mag = neg ? (32'd0 - value) : value;
      nd  = 0;
      do begin
         digits[nd] = DIGIT_W'(mag % 32'd10);
         mag        = mag / 32'd10;
         nd++;
      end while (mag != 0 && nd < MAX_DIGITS);
      if (neg) begin
         tc.ch   = MINUS_CODE;
         tc.last = 1'b0;
         expected_text.push_back(tc);
      end
      for (int i = nd - 1; i >= 0; i--) begin
         tc.ch   = DIGIT_BASE_CODE + CHAR_W'(digits[i]);
         tc.last = (i == 0);
         expected_text.push_back(tc);
      end
   endfunction

   function automatic logic [VALUE_W-1:0] random_value();
      int          k;
      logic        neg;
      int unsigned lo;
      int unsigned hi;
      int unsigned mag;
      if ($urandom_range(0, 3) == 0) return $urandom;
      k   = $urandom_range(1, MAX_DIGITS);
      neg = 1'($urandom_range(0, 1));
      lo  = 1;
      for (int i = 1; i < k; i++) lo = lo * 10;
      if (k == 1) begin
         lo = 0;
         hi = 9;
      end else if (k == MAX_DIGITS) begin
         hi = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         hi = lo * 10 - 1;
      end
      mag = $urandom_range(hi, lo);
      return neg ? (32'd0 - mag) : mag;
   endfunction

   task automatic send_value(input logic [VALUE_W-1:0] value);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      predict_text(value);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         repeat ($urandom_range(0, 4)) @(negedge clock);
      end
   endtask

   task automatic test_extremes();
      logic [VALUE_W-1:0] vals[$];
      vals = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'hFFFF_FFF6, 32'hFFFF_FFF7,
               32'd99, 32'd100, 32'd999_999_999, 32'd1_000_000_000, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h8000_0001, 32'hC465_3600, 32'd2_000_000_000,
               32'hAAAA_AAAA, 32'h5555_5555, 32'd1_234_567_890, 32'd0, 32'h8000_0000};
      foreach (vals[i]) send_value(vals[i]);
   endtask

   task automatic test_random_values(input int count);
      repeat (count) send_value(random_value());
   endtask

   // receiver stalls for a long stretch while the sender keeps offering numbers
   task automatic test_output_holdoff();
      int saved_pct;
      saved_pct     = send_idle_pct;
      send_idle_pct = 0;
      @(posedge clock);
      hold_cycles = HOLD_OFF_CYCLES;
      repeat (12) send_value(random_value());
      send_idle_pct = saved_pct;
   endtask

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles--;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      text_char_type exp_c;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_text.size() == 0) begin
            $display("%0t: unexpected beat char %0d last %0b", $time, rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            exp_c = expected_text.pop_front();
            if (rsp_tdata !== exp_c.ch) begin
               $display("%0t: char expected %0d got %0d", $time, exp_c.ch, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== exp_c.last) begin
               $display("%0t: last expected %0b got %0b", $time, exp_c.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d chars pending", $time, expected_text.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      fail_count    = 0;
      hold_cycles   = 0;
      quiet_cycles  = 0;
      send_idle_pct = 24;
      rsp_idle_pct  = 59;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_extremes();
      test_output_holdoff();
      test_random_values(145);
      send_idle_pct = 59;
      rsp_idle_pct  = 24;
      test_random_values(145);
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      test_random_values(145);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_text.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> files.f
design/itoa_pkg.sv
design/itoa_front.sv
design/itoa_back.sv
design/int_to_decimal_ascii_top.sv
design/itoa_checker.sv
tb/sv/tb.sv
